/* rtl/core/gb5_pkg.sv */
// Shared types and codes for the 5x5 Gaussian blur block.
package gb5_pkg;

	// Register map of the configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Transaction kinds on the source channel.
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam int CHAN_W  = 8;
	localparam int PIXEL_W = 3 * CHAN_W;

	typedef struct packed {
		logic              action;
		logic [CHAN_W-1:0] blue_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] red_in;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] red_out;
		logic              frame_last;
	} out_item_t;

endpackage

/* rtl/core/gb5_ram.sv */
// Generic simple dual-read RAM with one write port and registered reads.
module gb5_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	output logic [DATA_W-1:0] rd_data_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [DATA_W-1:0] rd_data_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Read-before-write: a read of the entry being written returns the old data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

/* rtl/core/gaussian_blur_5x5_rgb.sv */
// Top level of the 5x5 Gaussian blur: line stores, window, filter pipeline and output queue.
//
// The block takes one source transaction per clock and gives at most one result per
// transaction. Pixels arrive in raster order; each is written into one of four line-store
// banks (one RAM per row slot, MAX_WIDTH deep) at the same clock edge that reads the four
// stored pixels of its column, so a pixel enters the 5x5 window on the next clock. Interior
// pixels are convolved per channel with the kernel {1,2,4,2,1} x {1,2,4,2,1} and divided by
// 100, truncating; pixels within two of any frame edge are copied from the line store
// unchanged. A result is released once 2*width+2 pixels stand behind it, and a flush
// transaction releases the next pending pixel as a plain copy, which is how the tail of a
// frame is drained. Each result is registered through the filter pipeline into the output
// queue. The source side sustains one transaction per cycle as long as fewer than eight
// results are accepted but not yet taken; the eight-entry output queue sets that figure, and
// src_ready drops only when it would overflow. A configuration write takes effect at once,
// restarts the frame at row 0, column 0 and drops all pending pixels; sizes of 0 act as 1 and
// sizes above MAX_WIDTH or MAX_HEIGHT act as the maximum. The line stores need no clearing
// pass after reset: no result depends on an entry that was never written.
module gaussian_blur_5x5_rgb #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_ready,
	input  gb5_pkg::in_item_t                src_data,
	output logic                             dst_valid,
	input  logic                             dst_ready,
	output gb5_pkg::out_item_t               dst_data,
	input  logic                             cfg_wr_en,
	input  logic [gb5_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [gb5_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import gb5_pkg::*;

	localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WB       = $clog2(MAX_WIDTH + 1);
	localparam int HB       = $clog2(MAX_HEIGHT + 1);
	localparam int PB       = $clog2(2 * MAX_WIDTH + 4);
	localparam int W_RST    = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
	localparam int H_RST    = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

	// Output queue: its depth bounds the number of results in flight.
	localparam int QDEPTH = 8;
	localparam int QA     = $clog2(QDEPTH);
	localparam int RES_W  = $clog2(QDEPTH + 1);

	// Division by the kernel sum 100 as a multiply by a scaled reciprocal.
	localparam int HSUM_W    = 12;
	localparam int VSUM_W    = 15;
	localparam int DIV_MUL_W = 13;
	localparam int PROD_W    = VSUM_W + DIV_MUL_W;
	localparam int DIV_SHIFT = 19;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 13'd5243;

	// ------------------------------------------------------------------
	// Frame size registers and stream counters
	// ------------------------------------------------------------------
	logic [WB-1:0]       w_q;
	logic [HB-1:0]       h_q;
	logic [COL_BITS-1:0] w_last_q;
	logic [ROW_BITS-1:0] h_last_q;
	logic [PB-1:0]       thr_q;

	logic [COL_BITS-1:0] in_col_q;
	logic [1:0]          in_slot_q;
	logic [COL_BITS-1:0] out_col_q;
	logic [ROW_BITS-1:0] out_row_q;
	logic [1:0]          out_slot_q;
	logic [PB-1:0]       pending_q;
	logic [RES_W-1:0]    reserved_q;

	logic [31:0] w_eff;
	logic [31:0] h_eff;
	logic [31:0] w_req;
	logic [31:0] h_req;

	always_comb begin
		w_req = 32'(cfg_data[WIDTH_REG_W-1:0]);
		h_req = 32'(cfg_data[HEIGHT_REG_W-1:0]);
		if (w_req == 32'd0) begin
			w_eff = 32'd1;
		end else if (w_req > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = w_req;
		end
		if (h_req == 32'd0) begin
			h_eff = 32'd1;
		end else if (h_req > 32'(MAX_HEIGHT)) begin
			h_eff = 32'(MAX_HEIGHT);
		end else begin
			h_eff = h_req;
		end
	end

	// Decisions made at the accepting edge.
	logic accept;
	logic is_pix;
	logic emit_now;
	logic blur_now;
	logic last_now;
	logic interior;
	logic pop;
	logic [PIXEL_W-1:0] src_pix;

	assign src_pix = {src_data.red_in, src_data.green_in, src_data.blue_in};
	assign is_pix  = (src_data.action == ACT_PIXEL);
	assign src_ready = (reserved_q < RES_W'(QDEPTH));
	assign accept = src_valid && src_ready;
	assign pop = dst_valid && dst_ready;

	// A pixel releases the oldest pending output once the lag of 2*W+2 is full; a
	// flush releases it whenever anything is pending.
	assign emit_now = is_pix ? (pending_q >= thr_q) : (pending_q != '0);

	// Only pixels at least two away from every edge are blurred.
	assign interior = (out_row_q >= ROW_BITS'(2))
		&& ((HB + 1)'(out_row_q) + (HB + 1)'(2) < (HB + 1)'(h_q))
		&& (out_col_q >= COL_BITS'(2))
		&& ((WB + 1)'(out_col_q) + (WB + 1)'(2) < (WB + 1)'(w_q));
	assign blur_now = is_pix && interior;
	assign last_now = (out_row_q == h_last_q) && (out_col_q == w_last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= WB'(W_RST);
			h_q        <= HB'(H_RST);
			w_last_q   <= COL_BITS'(W_RST - 1);
			h_last_q   <= ROW_BITS'(H_RST - 1);
			thr_q      <= PB'(2 * W_RST + 2);
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pending_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: begin
					w_q      <= WB'(w_eff);
					w_last_q <= COL_BITS'(w_eff - 32'd1);
					thr_q    <= PB'(2 * w_eff + 32'd2);
				end
				REG_IMAGE_HEIGHT: begin
					h_q      <= HB'(h_eff);
					h_last_q <= ROW_BITS'(h_eff - 32'd1);
				end
			endcase
			in_col_q   <= '0;
			in_slot_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_slot_q <= '0;
			pending_q  <= '0;
		end else if (accept) begin
			if (is_pix) begin
				if (in_col_q == w_last_q) begin
					in_col_q  <= '0;
					in_slot_q <= in_slot_q + 2'd1;
				end else begin
					in_col_q <= in_col_q + COL_BITS'(1);
				end
				if (!emit_now) begin
					pending_q <= pending_q + PB'(1);
				end
			end else if (emit_now) begin
				pending_q <= pending_q - PB'(1);
			end
			if (emit_now) begin
				if (out_col_q == w_last_q) begin
					out_col_q  <= '0;
					out_slot_q <= out_slot_q + 2'd1;
					out_row_q  <= (out_row_q == h_last_q) ? '0 : out_row_q + ROW_BITS'(1);
				end else begin
					out_col_q <= out_col_q + COL_BITS'(1);
				end
			end
		end
	end

	// Results reserved in the pipeline plus those waiting in the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else begin
			reserved_q <= reserved_q + RES_W'(accept && emit_now && !cfg_wr_en) - RES_W'(pop);
		end
	end

	// ------------------------------------------------------------------
	// Line stores: one bank per row slot. The bank of the current row is
	// written while all four are read at the same column, read-before-write.
	// Port B reads the pending output position for the copy path.
	// ------------------------------------------------------------------
	logic [PIXEL_W-1:0] rd_a [4];
	logic [PIXEL_W-1:0] rd_b [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		gb5_ram #(
			.DATA_W(PIXEL_W),
			.DEPTH (MAX_WIDTH)
		) u_line (
			.clk      (clk),
			.wr_en    (accept && is_pix && !cfg_wr_en && (in_slot_q == 2'(b))),
			.wr_addr  (in_col_q),
			.wr_data  (src_pix),
			.rd_addr_a(in_col_q),
			.rd_data_a(rd_a[b]),
			.rd_addr_b(out_col_q),
			.rd_data_b(rd_b[b])
		);
	end

	// ------------------------------------------------------------------
	// Stage 1: line-store data valid; the window shifts at the end of it.
	// ------------------------------------------------------------------
	logic               shift_s1;
	logic               emit_s1;
	logic               blur_s1;
	logic               last_s1;
	logic [1:0]         in_slot_s1;
	logic [1:0]         oslot_s1;
	logic [PIXEL_W-1:0] pix_s1;

	logic               emit_s2, emit_s3, emit_s4, emit_s5;
	logic               blur_s2, blur_s3, blur_s4, blur_s5;
	logic               last_s2, last_s3, last_s4, last_s5;
	logic [PIXEL_W-1:0] copy_s2, copy_s3, copy_s4, copy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			emit_s2  <= 1'b0;
			emit_s3  <= 1'b0;
			emit_s4  <= 1'b0;
			emit_s5  <= 1'b0;
		end else begin
			shift_s1 <= accept && is_pix && !cfg_wr_en;
			emit_s1  <= accept && emit_now && !cfg_wr_en;
			emit_s2  <= emit_s1;
			emit_s3  <= emit_s2;
			emit_s4  <= emit_s3;
			emit_s5  <= emit_s4;
		end
	end

	always_ff @(posedge clk) begin
		blur_s1    <= blur_now;
		last_s1    <= last_now;
		in_slot_s1 <= in_slot_q;
		oslot_s1   <= out_slot_q;
		pix_s1     <= src_pix;

		blur_s2 <= blur_s1;
		last_s2 <= last_s1;
		copy_s2 <= rd_b[oslot_s1];

		blur_s3 <= blur_s2;
		last_s3 <= last_s2;
		copy_s3 <= copy_s2;

		blur_s4 <= blur_s3;
		last_s4 <= last_s3;
		copy_s4 <= copy_s3;

		blur_s5 <= blur_s4;
		last_s5 <= last_s4;
		copy_s5 <= copy_s4;
	end

	// New window column: rows 0..3 come from the line stores, oldest row first,
	// and row 4 is the incoming pixel.
	logic [PIXEL_W-1:0] col_new [5];
	logic [PIXEL_W-1:0] win_q [5][5];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			col_new[r] = rd_a[2'(in_slot_s1 + 2'(r))];
		end
		col_new[4] = pix_s1;
	end

	always_ff @(posedge clk) begin
		if (shift_s1) begin
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++) begin
					win_q[r][c] <= win_q[r][c + 1];
				end
				win_q[r][4] <= col_new[r];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 2 to 5: separable kernel, horizontal then vertical, then divide.
	// ------------------------------------------------------------------
	function automatic logic [HSUM_W-1:0] tap_row(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] c,
		input logic [CHAN_W-1:0] d, input logic [CHAN_W-1:0] e);
		tap_row = HSUM_W'(a) + (HSUM_W'(b) << 1) + (HSUM_W'(c) << 2)
			+ (HSUM_W'(d) << 1) + HSUM_W'(e);
	endfunction

	function automatic logic [VSUM_W-1:0] tap_col(input logic [HSUM_W-1:0] a,
		input logic [HSUM_W-1:0] b, input logic [HSUM_W-1:0] c,
		input logic [HSUM_W-1:0] d, input logic [HSUM_W-1:0] e);
		tap_col = VSUM_W'(a) + (VSUM_W'(b) << 1) + (VSUM_W'(c) << 2)
			+ (VSUM_W'(d) << 1) + VSUM_W'(e);
	endfunction

	logic [HSUM_W-1:0] hsum_s3 [5][3];
	logic [VSUM_W-1:0] vsum_s4 [3];
	logic [PROD_W-1:0] prod_s5 [3];

	always_ff @(posedge clk) begin
		for (int r = 0; r < 5; r++) begin
			for (int ch = 0; ch < 3; ch++) begin
				hsum_s3[r][ch] <= tap_row(win_q[r][0][ch * CHAN_W +: CHAN_W],
					win_q[r][1][ch * CHAN_W +: CHAN_W], win_q[r][2][ch * CHAN_W +: CHAN_W],
					win_q[r][3][ch * CHAN_W +: CHAN_W], win_q[r][4][ch * CHAN_W +: CHAN_W]);
			end
		end
		for (int ch = 0; ch < 3; ch++) begin
			vsum_s4[ch] <= tap_col(hsum_s3[0][ch], hsum_s3[1][ch], hsum_s3[2][ch],
				hsum_s3[3][ch], hsum_s3[4][ch]);
			prod_s5[ch] <= PROD_W'(vsum_s4[ch]) * PROD_W'(DIV_MUL);
		end
	end

	// Result selection at the end of the pipeline.
	out_item_t res_s5;

	always_comb begin
		if (blur_s5) begin
			res_s5.blue_out  = prod_s5[0][DIV_SHIFT +: CHAN_W];
			res_s5.green_out = prod_s5[1][DIV_SHIFT +: CHAN_W];
			res_s5.red_out   = prod_s5[2][DIV_SHIFT +: CHAN_W];
		end else begin
			res_s5.blue_out  = copy_s5[0 +: CHAN_W];
			res_s5.green_out = copy_s5[CHAN_W +: CHAN_W];
			res_s5.red_out   = copy_s5[2 * CHAN_W +: CHAN_W];
		end
		res_s5.frame_last = last_s5;
	end

	// ------------------------------------------------------------------
	// Output queue. The reservation count at the source keeps it from overflowing.
	// ------------------------------------------------------------------
	out_item_t        fifo_q [QDEPTH];
	logic [QA-1:0]    wr_ptr_q;
	logic [QA-1:0]    rd_ptr_q;
	logic [RES_W-1:0] fifo_cnt_q;

	always_ff @(posedge clk) begin
		if (emit_s5) begin
			fifo_q[wr_ptr_q] <= res_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (emit_s5) begin
				wr_ptr_q <= wr_ptr_q + QA'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + RES_W'(emit_s5) - RES_W'(pop);
		end
	end

	assign dst_valid = (fifo_cnt_q != '0);
	assign dst_data  = fifo_q[rd_ptr_q];

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_reserve_bound: assert property (@(posedge clk) disable iff (!arst_n)
		reserved_q <= RES_W'(QDEPTH))
		else $error("result reservation count exceeds the queue depth");

	a_queue_covered: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= reserved_q)
		else $error("output queue holds more results than were reserved");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= thr_q)
		else $error("pending pixel count exceeds the row lag");

	a_valid_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(emit_s5))
		else $error("output became valid without a result entering the queue");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the 5x5 Gaussian blur block, with its own pixel-exact predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import gb5_pkg::*;

	// Sizes of the instance under test. The predictor keeps its line stores at the same depth.
	localparam int MAX_W = 1024;
	localparam int MAX_H = 4096;

	// Separable kernel taps and their full 2-D sum; the block divides by 100, truncating.
	localparam int unsigned KERNEL_TAP [5] = '{1, 2, 4, 2, 1};
	localparam int unsigned KERNEL_SUM = 100;

	// Run control. The cycle limit allows for every transaction on both sides waiting out
	// the longest idle stretch, plus the long receiver hold, several times over.
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned RANDOM_ITEMS  = 380;
	localparam int unsigned WIDE_PIXELS   = 150;
	localparam int unsigned TALL_PIXELS   = 40;
	localparam int unsigned HOLD_AFTER    = 100;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned MAX_REPORTS   = 100;

	// One pixel as the predictor keeps it in its line stores and window.
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// One row of the directed table: either a register write or a source transaction.
	// Where the outcome is obvious, the expected result is typed in; otherwise the
	// predictor supplies it.
	typedef struct packed {
		logic                   is_cfg;
		logic [CFG_INDEX_W-1:0] reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
		in_item_t               item;
		logic                   typed;
		logic                   typed_hit;
		out_item_t              typed_res;
	} plan_row_t;

	// Clock, reset and every block input start at a known value.
	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   src_valid = 1'b0;
	logic                   src_ready;
	in_item_t               src_data = '0;
	logic                   dst_valid;
	logic                   dst_ready = 1'b0;
	out_item_t              dst_data;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	gaussian_blur_5x5_rgb #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data(src_data),
		.dst_valid(dst_valid),
		.dst_ready(dst_ready),
		.dst_data(dst_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------------------
	// Predictor state: four row slots, the 5x5 window, the frame position on the source and
	// result sides, and the number of accepted pixels whose result is still owed.
	// ------------------------------------------------------------------------------------
	rgb_t                    line_buf [4][MAX_W];
	rgb_t                    win [5][5];
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	int unsigned             src_col;
	int unsigned             dst_col;
	int unsigned             dst_row;
	logic [1:0]              src_bank;
	logic [1:0]              dst_bank;
	int unsigned             backlog;

	// Results the block still owes, oldest first.
	out_item_t expected_pixels [$];

	int unsigned mismatches = 0;
	int unsigned pixels_out = 0;
	int unsigned cycles = 0;
	int unsigned src_sent = 0;
	bit          src_calm = 1'b0;

	// Receiver idling state; only the receiver process touches these.
	int unsigned sink_cycles = 0;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	bit          sink_calm = 1'b0;

	plan_row_t plan [$];

	// Effective frame sizes: zero acts as one, anything above the maximum as the maximum.
	function automatic int unsigned frame_w();
		int unsigned v = width_reg;
		if (v == 0) v = 1;
		if (v > MAX_W) v = MAX_W;
		return v;
	endfunction

	function automatic int unsigned frame_h();
		int unsigned v = height_reg;
		if (v == 0) v = 1;
		if (v > MAX_H) v = MAX_H;
		return v;
	endfunction

	// A size write restarts the frame and forgets every pixel still owed a result.
	function automatic void restart_frame();
		src_col = 0;
		src_bank = '0;
		dst_col = 0;
		dst_row = 0;
		dst_bank = '0;
		backlog = 0;
	endfunction

	function automatic void blur_reset();
		foreach (line_buf[b, c]) line_buf[b][c] = '0;
		foreach (win[r, c]) win[r][c] = '0;
		width_reg = WIDTH_REG_W'(640);
		height_reg = HEIGHT_REG_W'(480);
		restart_frame();
	endfunction

	function automatic void blur_configure(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_IMAGE_WIDTH: width_reg = val[WIDTH_REG_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
		endcase
		restart_frame();
	endfunction

	// Produces the next owed result in raster order. Interior pixels are blurred from the
	// window unless this is a flush, which always hands out a plain copy.
	function automatic out_item_t release_pixel(input bit may_blur);
		int unsigned w = frame_w();
		int unsigned h = frame_h();
		int unsigned acc_b, acc_g, acc_r, wt;
		rgb_t px;
		out_item_t res;
		if (may_blur && dst_row >= 2 && dst_row + 2 < h && dst_col >= 2 && dst_col + 2 < w) begin
			acc_b = 0;
			acc_g = 0;
			acc_r = 0;
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 5; c++) begin
					wt = KERNEL_TAP[r] * KERNEL_TAP[c];
					acc_b += win[r][c].blue * wt;
					acc_g += win[r][c].green * wt;
					acc_r += win[r][c].red * wt;
				end
			end
			px.blue = CHAN_W'(acc_b / KERNEL_SUM);
			px.green = CHAN_W'(acc_g / KERNEL_SUM);
			px.red = CHAN_W'(acc_r / KERNEL_SUM);
		end else begin
			px = line_buf[dst_bank][dst_col];
		end
		res.blue_out = px.blue;
		res.green_out = px.green;
		res.red_out = px.red;
		res.frame_last = (dst_row == h - 1 && dst_col == w - 1);
		dst_col++;
		if (dst_col >= w) begin
			dst_col = 0;
			dst_bank++;
			dst_row++;
			if (dst_row >= h) dst_row = 0;
		end
		return res;
	endfunction

	// Advances the predictor by one accepted transaction; returns 1 when it owes a result.
	function automatic bit predict_blur(input in_item_t it, output out_item_t res);
		int unsigned w = frame_w();
		rgb_t pix;
		bit hit = 1'b0;
		res = '0;
		if (it.action == ACT_PIXEL) begin
			pix = {it.red_in, it.green_in, it.blue_in};
			// The four stored rows of this column and the new pixel enter the window's right edge.
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++) win[r][c] = win[r][c + 1];
				win[r][4] = (r < 4) ? line_buf[2'(src_bank + r)][src_col] : pix;
			end
			backlog++;
			if (backlog > 2 * w + 2) begin
				res = release_pixel(1'b1);
				backlog--;
				hit = 1'b1;
			end
			line_buf[src_bank][src_col] = pix;
			src_col++;
			if (src_col >= w) begin
				src_col = 0;
				src_bank++;
			end
		end else if (backlog != 0) begin
			res = release_pixel(1'b0);
			backlog--;
			hit = 1'b1;
		end
		return hit;
	endfunction

	// Directed table helpers.
	function automatic plan_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		plan_row_t row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic plan_row_t item_row(input logic act, input logic [7:0] b, g, r);
		plan_row_t row = '0;
		row.item = '{action: act, blue_in: b, green_in: g, red_in: r};
		return row;
	endfunction

	function automatic plan_row_t quiet_row(input logic act, input logic [7:0] b, g, r);
		plan_row_t row = item_row(act, b, g, r);
		row.typed = 1'b1;
		return row;
	endfunction

	function automatic plan_row_t gives_row(input logic act, input logic [7:0] b, g, r,
			input logic [7:0] eb, eg, er, input logic last);
		plan_row_t row = quiet_row(act, b, g, r);
		row.typed_hit = 1'b1;
		row.typed_res = '{blue_out: eb, green_out: eg, red_out: er, frame_last: last};
		return row;
	endfunction

	// Random payload, with flat black or white pixels now and then.
	function automatic in_item_t make_item(input logic act);
		in_item_t it;
		it.action = act;
		it.blue_in = CHAN_W'($urandom);
		it.green_in = CHAN_W'($urandom);
		it.red_in = CHAN_W'($urandom);
		case ($urandom_range(0, 9))
			0: {it.blue_in, it.green_in, it.red_in} = '1;
			1: {it.blue_in, it.green_in, it.red_in} = '0;
			default: ;
		endcase
		return it;
	endfunction

	// Idle length: mostly none, often a few cycles, now and then a long one.
	function automatic int unsigned pick_gap(input bit calm);
		int unsigned p = $urandom_range(0, 99);
		if (calm || p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void complain(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, what);
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want, got);
		if (got !== want)
			complain($sformatf("%s mismatch: expected %0d, actual %0d", name, want, got));
	endfunction

	// Compares one result transaction with the oldest owed result.
	function automatic void check_pixel(input out_item_t got);
		out_item_t want;
		pixels_out++;
		if (expected_pixels.size() == 0) begin
			complain($sformatf("unexpected result: expected none, actual b=%0d g=%0d r=%0d last=%0d",
				got.blue_out, got.green_out, got.red_out, got.frame_last));
			return;
		end
		want = expected_pixels.pop_front();
		check_field("blue_out", want.blue_out, got.blue_out);
		check_field("green_out", want.green_out, got.green_out);
		check_field("red_out", want.red_out, got.red_out);
		check_field("frame_last", 8'(want.frame_last), 8'(got.frame_last));
	endfunction

	// Offers one source transaction after a random gap and holds it until it is accepted.
	// Valid only drops when a gap follows, so a back-to-back transaction never sees valid
	// lowered and raised within the same time step.
	task automatic offer(input in_item_t it, output bit hit, output out_item_t res);
		int unsigned gap = pick_gap(src_calm);
		if (gap != 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= it;
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		hit = predict_blur(it, res);
		src_sent++;
		if (src_sent % 64 == 0) src_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_item(input in_item_t it);
		bit hit;
		out_item_t res;
		offer(it, hit, res);
		if (hit) expected_pixels.push_back(res);
	endtask

	// Register writes happen only with the block idle: every owed result delivered, then a
	// short settle so that a pixel that owes nothing has left the pipeline too.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		src_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		blur_configure(idx, val);
	endtask

	task automatic apply_row(input plan_row_t row);
		bit hit;
		out_item_t res;
		if (row.is_cfg) begin
			write_reg(row.reg_idx, row.reg_val);
		end else begin
			offer(row.item, hit, res);
			if (!row.typed) begin
				if (hit) expected_pixels.push_back(res);
			end else if (row.typed_hit) begin
				expected_pixels.push_back(row.typed_res);
			end
		end
	endtask

	// Hands out flushes until nothing is owed any more.
	task automatic drain_frame();
		while (backlog != 0) send_item(make_item(ACT_FLUSH));
	endtask

	// Receiver: checks every result transaction and idles at random. Once, after a hundred
	// results, it holds off for a long stretch so that the output queue fills and the block
	// has to stall its source side while the sender keeps offering.
	always @(posedge clk) begin
		if (arst_n && dst_valid && dst_ready) check_pixel(dst_data);
		if (!hold_done && pixels_out >= HOLD_AFTER) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		sink_cycles++;
		if (sink_cycles % 128 == 0) sink_calm = ($urandom_range(0, 3) == 0);
		if (hold_left != 0) begin
			hold_left--;
			dst_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			dst_ready <= 1'b0;
		end else begin
			stall_left = pick_gap(sink_calm);
			if (stall_left != 0) begin
				stall_left--;
				dst_ready <= 1'b0;
			end else begin
				dst_ready <= 1'b1;
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still owed", $time, expected_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int unsigned random_items;
		int unsigned total;
		logic [CFG_DATA_W-1:0] wv, hv;
		in_item_t it;

		blur_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. It opens at the reset sizes of 640 x 480, where no pixel is released
		// on its own for a long time, so flushes show the single pending pixel directly.
		plan = '{
			// Flush with nothing pending gives nothing.
			quiet_row(ACT_FLUSH, 8'h3C, 8'hC3, 8'h99),
			quiet_row(ACT_PIXEL, 8'hFF, 8'h00, 8'h80),
			gives_row(ACT_FLUSH, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h80, 1'b0),
			quiet_row(ACT_FLUSH, 8'hFF, 8'hFF, 8'hFF),
			// Zero sizes act as one: every 1x1 frame ends on its only pixel, and the
			// release lag shrinks to four pixels.
			cfg_row(REG_IMAGE_WIDTH, 13'd0),
			cfg_row(REG_IMAGE_HEIGHT, 13'd0),
			quiet_row(ACT_PIXEL, 8'h00, 8'hFF, 8'h00),
			quiet_row(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF),
			quiet_row(ACT_PIXEL, 8'h00, 8'h00, 8'h00),
			quiet_row(ACT_PIXEL, 8'hA5, 8'h5A, 8'hC3),
			gives_row(ACT_PIXEL, 8'h12, 8'h34, 8'h56, 8'h00, 8'hFF, 8'h00, 1'b1),
			gives_row(ACT_FLUSH, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1),
			gives_row(ACT_FLUSH, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1),
			quiet_row(ACT_PIXEL, 8'h01, 8'h02, 8'h04),
			// An oversized width, with the unused upper data bits set, clamps to the
			// maximum and throws away the three pixels still pending.
			cfg_row(REG_IMAGE_WIDTH, 13'h1FFF),
			quiet_row(ACT_FLUSH, 8'h55, 8'hAA, 8'h55),
			quiet_row(ACT_PIXEL, 8'h7F, 8'h80, 8'h01),
			gives_row(ACT_FLUSH, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h80, 8'h01, 1'b0),
			cfg_row(REG_IMAGE_HEIGHT, 13'h1FFF),
			// Tiny 3x2 frames back to back, left to the predictor.
			cfg_row(REG_IMAGE_WIDTH, 13'd3),
			cfg_row(REG_IMAGE_HEIGHT, 13'd2),
			item_row(ACT_PIXEL, 8'h10, 8'h20, 8'h30),
			item_row(ACT_PIXEL, 8'h40, 8'h50, 8'h60),
			item_row(ACT_PIXEL, 8'h70, 8'h80, 8'h90),
			item_row(ACT_PIXEL, 8'hA0, 8'hB0, 8'hC0),
			item_row(ACT_PIXEL, 8'hD0, 8'hE0, 8'hF0),
			item_row(ACT_PIXEL, 8'h01, 8'h23, 8'h45),
			item_row(ACT_PIXEL, 8'h67, 8'h89, 8'hAB),
			item_row(ACT_PIXEL, 8'hCD, 8'hEF, 8'hFE),
			item_row(ACT_PIXEL, 8'hDC, 8'hBA, 8'h98)
		};
		foreach (plan[i]) apply_row(plan[i]);

		// Widest frame, one row high: the lag far exceeds the pixels sent, so every result
		// comes from a flush. The receiver's long hold falls in this stretch of back-to-back
		// flushes.
		write_reg(REG_IMAGE_WIDTH, 13'd2047);
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		repeat (WIDE_PIXELS) send_item(make_item(ACT_PIXEL));
		drain_frame();

		// Tallest frame, one column wide: the lag shrinks to four pixels and every result
		// is a copy; each one that a pixel releases is read back from the slot being rewritten.
		write_reg(REG_IMAGE_WIDTH, 13'd0);
		write_reg(REG_IMAGE_HEIGHT, 13'd8191);
		repeat (TALL_PIXELS) send_item(make_item(ACT_PIXEL));
		drain_frame();

		// Random part: mostly whole frames of random pixels at small sizes, so that interior
		// pixels get blurred, with stray mid-frame flushes, frames cut short by a size write,
		// and now and then a size anywhere in the register range.
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					wv = CFG_DATA_W'($urandom_range(0, 8191));
					hv = CFG_DATA_W'($urandom_range(0, 8191));
				end
				1, 2: begin
					wv = CFG_DATA_W'($urandom_range(5, 40));
					hv = CFG_DATA_W'($urandom_range(5, 8));
				end
				default: begin
					wv = CFG_DATA_W'($urandom_range(1, 9));
					hv = CFG_DATA_W'($urandom_range(1, 9));
				end
			endcase
			case ($urandom_range(0, 5))
				0: write_reg(REG_IMAGE_WIDTH, wv);
				1: write_reg(REG_IMAGE_HEIGHT, hv);
				default: begin
					write_reg(REG_IMAGE_WIDTH, wv);
					write_reg(REG_IMAGE_HEIGHT, hv);
				end
			endcase

			total = frame_w() * frame_h() * $urandom_range(1, 2);
			if (total > 150) total = $urandom_range(20, 150);
			for (int k = 0; k < total; k++) begin
				it = make_item(($urandom_range(0, 29) == 0) ? ACT_FLUSH : ACT_PIXEL);
				if (it.action == ACT_PIXEL || backlog != 0) random_items++;
				send_item(it);
			end

			// Usually drain the tail of the frame, sometimes with extra empty flushes;
			// otherwise the next size write drops whatever is still pending.
			if ($urandom_range(0, 7) != 0) begin
				random_items += backlog;
				drain_frame();
				repeat ($urandom_range(0, 2)) send_item(make_item(ACT_FLUSH));
			end
		end

		// Let every owed result arrive, then watch a little longer for strays.
		src_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
